// ----- rtl/format_spec_type_extractor_assert.svh -----
// Assertion macros shared by the checker of the format specifier type extractor.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef FORMAT_SPEC_TYPE_EXTRACTOR_ASSERT_SVH
`define FORMAT_SPEC_TYPE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define FSTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fste assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted
`define FSTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fste assertion failed: next-cycle implication");

`endif

// ----- rtl/fste_pkg.sv -----
// Package of the format specifier type extractor: result type, queue depth,
// parser phase and length prefix codes, character constants. No dependencies.
`default_nettype none

package fste_pkg;

    // Result item as it travels through the output queue
    typedef struct packed {
        logic [7:0] code_char;
        logic       is_status;
        logic       format_ok;
        logic       run_last;
    } t_result;

    // Result queue depth; a power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;

    // Parser phase codes
    localparam logic [2:0] PH_LIT  = 3'd0;
    localparam logic [2:0] PH_CONV = 3'd1;
    localparam logic [2:0] PH_I1   = 3'd2;
    localparam logic [2:0] PH_I2   = 3'd3;
    localparam logic [2:0] PH_T1   = 3'd4;
    localparam logic [2:0] PH_T2   = 3'd5;
    localparam logic [2:0] PH_T3   = 3'd6;
    localparam logic [2:0] PH_SKIP = 3'd7;

    // Length prefix codes
    localparam logic [2:0] PF_NONE = 3'd0;
    localparam logic [2:0] PF_H    = 3'd1;
    localparam logic [2:0] PF_L    = 3'd2;
    localparam logic [2:0] PF_BIGL = 3'd3;
    localparam logic [2:0] PF_I64  = 3'd4;

    // Characters the parser looks for
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_BIG_I = 8'h49;
    localparam logic [7:0] CH_BIG_L = 8'h4C;
    localparam logic [7:0] CH_BIG_P = 8'h50;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_SML_L = 8'h6C;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_BIG_S = 8'h53;
    localparam logic [7:0] CH_T     = 8'h74;

endpackage

`default_nettype wire

// ----- rtl/fste_in_if.sv -----
// Input channel of the format specifier type extractor: one format byte per
// transaction with its end-of-buffer mark. No dependencies.
`default_nettype none

interface fste_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       buffer_end;

    modport source (output valid, output char_in, output buffer_end, input ready);
    modport sink   (input valid, input char_in, input buffer_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/fste_out_if.sv -----
// Output channel of the format specifier type extractor: one type code or
// status item per transaction. No dependencies.
`default_nettype none

interface fste_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_char;
    logic       is_status;
    logic       format_ok;
    logic       run_last;

    modport source (output valid, output code_char, output is_status,
                    output format_ok, output run_last, input ready);
    modport sink   (input valid, input code_char, input is_status,
                    input format_ok, input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/format_spec_type_extractor.sv -----
// Top level of the format specifier type extractor: parser state, decoder and
// a four-entry result queue. Depends on fste_pkg, fste_in_if, fste_out_if, fste_decode.
//
// Usage:
//   i_in_ch carries one format byte (char_in) and its end-of-buffer mark
//   (buffer_end) per transaction; o_out_ch carries type codes and one status
//   item per string. i_cfg_wr_en / i_cfg_wr_data write check_only, which
//   drops type codes and leaves only the status items.
//   Each accepted byte is decoded in the cycle it is taken and its zero, one or
//   two results are written into the result queue; o_out_ch offers the head
//   of that queue once any older results in it have been taken.
//   Throughput is one byte per cycle while the output side takes one result
//   per cycle; a byte that causes two results needs two reads, so the rate
//   is set by the single-result read port of the queue.
//   Input ready is high while the queue has room for two more results, so a stalled
//   receiver holds results in the queue and input stops once fewer are free.
//   Synchronous active-low reset empties the queue, clears check_only and
//   returns the parser to literal text with no length prefix.
`default_nettype none

module format_spec_type_extractor (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_cfg_wr_en,
    input  wire logic    i_cfg_wr_data,
    fste_in_if.sink      i_in_ch,
    fste_out_if.source   o_out_ch
);

    localparam int PtrW = $clog2(fste_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(fste_pkg::QUEUE_DEPTH + 1);

    logic                 r_check_only;
    logic [2:0]           r_phase;
    logic [2:0]           r_prefix;
    fste_pkg::t_result    r_queue [fste_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]      r_wptr;
    logic [PtrW-1:0]      r_rptr;
    logic [CntW-1:0]      r_count;

    logic [2:0]           n_phase;
    logic [2:0]           n_prefix;
    logic [1:0]           dec_count;
    fste_pkg::t_result    dec_res0;
    fste_pkg::t_result    dec_res1;
    logic                 in_fire;
    logic                 out_fire;
    logic [1:0]           push_count;

    fste_decode u_decode (
        .i_phase      (r_phase),
        .i_prefix     (r_prefix),
        .i_check_only (r_check_only),
        .i_char       (i_in_ch.char_in),
        .i_last       (i_in_ch.buffer_end),
        .o_phase      (n_phase),
        .o_prefix     (n_prefix),
        .o_count      (dec_count),
        .o_res0       (dec_res0),
        .o_res1       (dec_res1)
    );

    // Handshakes
    assign i_in_ch.ready = (r_count <= CntW'(fste_pkg::QUEUE_DEPTH - 2));
    assign in_fire       = i_in_ch.valid && i_in_ch.ready;
    assign out_fire      = o_out_ch.valid && o_out_ch.ready;
    assign push_count    = in_fire ? dec_count : 2'd0;

    // Present the head of the queue
    assign o_out_ch.valid     = (r_count != '0);
    assign o_out_ch.code_char = r_queue[r_rptr].code_char;
    assign o_out_ch.is_status = r_queue[r_rptr].is_status;
    assign o_out_ch.format_ok = r_queue[r_rptr].format_ok;
    assign o_out_ch.run_last  = r_queue[r_rptr].run_last;

    // Configuration register and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_only <= 1'b0;
            r_phase      <= fste_pkg::PH_LIT;
            r_prefix     <= fste_pkg::PF_NONE;
        end else begin
            if (i_cfg_wr_en) begin
                r_check_only <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_phase  <= n_phase;
                r_prefix <= n_prefix;
            end
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PtrW'(push_count);
            if (out_fire) begin
                r_rptr <= r_rptr + PtrW'(1);
            end
            r_count <= r_count + CntW'(push_count) - CntW'(out_fire);
        end
    end

    // Write the results of an accepted transaction
    always_ff @(posedge i_clk) begin
        if (push_count != 2'd0) begin
            r_queue[r_wptr] <= dec_res0;
        end
        if (push_count == 2'd2) begin
            r_queue[r_wptr + PtrW'(1)] <= dec_res1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fste_decode.sv -----
// Single-pass byte decoder of the format specifier type extractor: next phase,
// next length prefix and up to two result items. Depends on fste_pkg.
`default_nettype none

module fste_decode (
    input  wire logic [2:0]       i_phase,
    input  wire logic [2:0]       i_prefix,
    input  wire logic             i_check_only,
    input  wire logic [7:0]       i_char,
    input  wire logic             i_last,
    output logic [2:0]            o_phase,
    output logic [2:0]            o_prefix,
    output logic [1:0]            o_count,
    output fste_pkg::t_result     o_res0,
    output fste_pkg::t_result     o_res1
);

    logic       want_code;
    logic [7:0] code_val;
    logic       st_en;
    logic       st_ok;
    logic       lit_en;
    logic [7:0] type_code;
    logic       code_en;

    // Type code of a conversion byte; zero for unknown, t for a pending t
    always_comb begin
        case (i_char) inside
            "c", "C":                     type_code = fste_pkg::CH_I;
            "d", "i", "o", "u", "x", "X": type_code = (i_prefix == fste_pkg::PF_I64) ?
                                                      fste_pkg::CH_BIG_I : fste_pkg::CH_I;
            "e", "E", "f", "g", "G":      type_code = fste_pkg::CH_F;
            "p":                          type_code = fste_pkg::CH_P;
            "s", "S": begin
                if (i_prefix == fste_pkg::PF_H) begin
                    type_code = fste_pkg::CH_S;
                end else if (i_prefix == fste_pkg::PF_L) begin
                    type_code = fste_pkg::CH_BIG_S;
                end else begin
                    type_code = i_char;
                end
            end
            "t":                          type_code = fste_pkg::CH_T;
            default:                      type_code = fste_pkg::CH_NUL;
        endcase
    end

    // Phase machine: decide code, status and next state for this byte
    always_comb begin
        want_code = 1'b0;
        code_val  = fste_pkg::CH_NUL;
        st_en     = 1'b0;
        st_ok     = 1'b0;
        lit_en    = 1'b0;
        o_phase   = i_phase;
        o_prefix  = i_prefix;

        unique case (i_phase)
            fste_pkg::PH_SKIP: begin
                if (i_last) begin
                    o_phase = fste_pkg::PH_LIT;
                end
            end
            fste_pkg::PH_T1, fste_pkg::PH_T2, fste_pkg::PH_T3: begin
                if (!i_last && ((i_phase == fste_pkg::PH_T1 && i_char == fste_pkg::CH_S) ||
                                (i_phase == fste_pkg::PH_T2 && i_char == fste_pkg::CH_T))) begin
                    o_phase = i_phase + 3'd1;
                end else begin
                    // resolve the pending t, then treat the byte as literal text
                    want_code = 1'b1;
                    code_val  = (i_phase == fste_pkg::PH_T3 && i_char == fste_pkg::CH_R) ?
                                fste_pkg::CH_BIG_P : fste_pkg::CH_I;
                    o_phase   = fste_pkg::PH_LIT;
                    lit_en    = 1'b1;
                end
            end
            fste_pkg::PH_I1, fste_pkg::PH_I2: begin
                if (i_phase == fste_pkg::PH_I1 && i_char == fste_pkg::CH_6) begin
                    o_phase = fste_pkg::PH_I2;
                    st_en   = i_last;
                end else if (i_phase == fste_pkg::PH_I2 && i_char == fste_pkg::CH_4) begin
                    o_prefix = fste_pkg::PF_I64;
                    o_phase  = fste_pkg::PH_CONV;
                    st_en    = i_last;
                end else begin
                    st_en = 1'b1;
                end
            end
            fste_pkg::PH_CONV: begin
                case (i_char) inside
                    "0", "#", "+", "-", " ", ["1":"9"], ".": begin
                        st_en = i_last;
                    end
                    fste_pkg::CH_STAR: begin
                        want_code = 1'b1;
                        code_val  = fste_pkg::CH_STAR;
                        st_en     = i_last;
                    end
                    default: begin
                        if (i_prefix == fste_pkg::PF_NONE && i_char == fste_pkg::CH_H) begin
                            o_prefix = fste_pkg::PF_H;
                            st_en    = i_last;
                        end else if (i_prefix == fste_pkg::PF_NONE &&
                                     i_char == fste_pkg::CH_SML_L) begin
                            o_prefix = fste_pkg::PF_L;
                            st_en    = i_last;
                        end else if (i_prefix == fste_pkg::PF_NONE &&
                                     i_char == fste_pkg::CH_BIG_L) begin
                            o_prefix = fste_pkg::PF_BIGL;
                            st_en    = i_last;
                        end else if (i_prefix == fste_pkg::PF_NONE &&
                                     i_char == fste_pkg::CH_BIG_I) begin
                            o_phase = fste_pkg::PH_I1;
                            st_en   = i_last;
                        end else if (type_code == fste_pkg::CH_NUL) begin
                            st_en = 1'b1;
                        end else if (type_code == fste_pkg::CH_T) begin
                            // hold the t code back unless the buffer ends here
                            o_phase   = fste_pkg::PH_T1;
                            want_code = i_last;
                            code_val  = fste_pkg::CH_I;
                            st_en     = i_last;
                            st_ok     = 1'b1;
                        end else begin
                            want_code = 1'b1;
                            code_val  = type_code;
                            o_phase   = fste_pkg::PH_LIT;
                            st_en     = i_last;
                            st_ok     = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                lit_en = 1'b1;
            end
        endcase

        // Literal text handling
        if (lit_en) begin
            if (i_char == fste_pkg::CH_NUL) begin
                st_en = 1'b1;
                st_ok = 1'b1;
            end else if (i_char < fste_pkg::CH_SPACE && i_char != fste_pkg::CH_TAB &&
                         i_char != fste_pkg::CH_LF && i_char != fste_pkg::CH_CR) begin
                st_en = 1'b1;
                st_ok = 1'b0;
            end else if (i_char == fste_pkg::CH_PCT) begin
                o_phase  = fste_pkg::PH_CONV;
                o_prefix = fste_pkg::PF_NONE;
                st_en    = i_last;
                st_ok    = 1'b0;
            end else begin
                st_en = i_last;
                st_ok = 1'b1;
            end
        end

        // A status ends the string: skip to the buffer end unless already there
        if (st_en) begin
            o_phase = i_last ? fste_pkg::PH_LIT : fste_pkg::PH_SKIP;
        end
    end

    assign code_en = want_code && !i_check_only;

    // Pack results: a code always comes before the status
    always_comb begin
        o_res0 = '0;
        o_res1 = '0;
        if (code_en) begin
            o_res0.code_char = code_val;
            o_res0.run_last  = !st_en;
            o_res1.is_status = 1'b1;
            o_res1.format_ok = st_ok;
            o_res1.run_last  = 1'b1;
        end else begin
            o_res0.is_status = 1'b1;
            o_res0.format_ok = st_ok;
            o_res0.run_last  = 1'b1;
        end
        o_count = {1'b0, code_en} + {1'b0, st_en};
    end

endmodule

`default_nettype wire

// ----- rtl/fste_checker.sv -----
// Port-level checker of the format specifier type extractor, bound to the top
// level. Depends on format_spec_type_extractor_assert.svh and the top level.
`default_nettype none
`include "format_spec_type_extractor_assert.svh"

module fste_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_code_char,
    input wire logic       i_is_status,
    input wire logic       i_format_ok,
    input wire logic       i_run_last
);

    // A stalled result holds until taken
    `FSTE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_code_char, i_is_status, i_format_ok, i_run_last}))

    // Status items carry no type code
    `FSTE_ASSERT_IMP(a_status_no_code, i_clk, i_rst_n, i_out_valid && i_is_status, i_code_char == 8'h00)

    // Status is always the final result of its transaction
    `FSTE_ASSERT_IMP(a_status_last, i_clk, i_rst_n, i_out_valid && i_is_status, i_run_last)

    // Type code items never claim a valid format and always carry a code
    `FSTE_ASSERT_IMP(a_code_shape, i_clk, i_rst_n, i_out_valid && !i_is_status, !i_format_ok && i_code_char != 8'h00)

endmodule

bind format_spec_type_extractor fste_checker u_fste_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_code_char (o_out_ch.code_char),
    .i_is_status (o_out_ch.is_status),
    .i_format_ok (o_out_ch.format_ok),
    .i_run_last  (o_out_ch.run_last)
);

`default_nettype wire

// ----- sim/format_spec_type_extractor_tb.sv -----
// Testbench of the format specifier type extractor: streams format strings
// through the byte channel and checks every type code and status item.
// Depends on fste_pkg, fste_in_if, fste_out_if and format_spec_type_extractor.
`timescale 1ns / 100ps

module format_spec_type_extractor_tb;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_fmt_byte;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    fste_in_if  in_ch ();
    fste_out_if out_ch ();

    format_spec_type_extractor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_ch       (in_ch),
        .o_out_ch      (out_ch)
    );

    // Format bytes waiting to be sent, results still owed by the block
    t_fmt_byte         pending_bytes [$];
    fste_pkg::t_result expected_results [$];
    fste_pkg::t_result step_out [$];

    // Shadow copy of the parser state and of check_only
    logic [2:0] pred_phase;
    logic [2:0] pred_prefix;
    logic       pred_check_only;

    int bytes_queued;
    int bytes_taken;
    int codes_seen;
    int statuses_seen;
    int mismatches;
    int settings_used;

    // Sender and receiver idling
    int tx_gap;
    bit tx_quiet;
    int rx_gap;
    bit rx_quiet;
    int rx_hold_left;
    int holds_done;
    int hold_at = 20;

    string conv_types = "cCdiouxXeEfgGpsSt";
    string conv_flags = "0#+- .123456789";
    string tstr_tail  = "str";

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Predictor: collect the results of one byte, mark the last, queue them
    task automatic emit_code(input logic [7:0] code);
        if (!pred_check_only)
            step_out.push_back('{code_char: code, is_status: 1'b0, format_ok: 1'b0,
                                 run_last: 1'b0});
    endtask

    task automatic emit_status(input logic ok, input logic last);
        step_out.push_back('{code_char: fste_pkg::CH_NUL, is_status: 1'b1, format_ok: ok,
                             run_last: 1'b0});
        pred_phase = last ? fste_pkg::PH_LIT : fste_pkg::PH_SKIP;
    endtask

    task automatic literal_byte(input logic [7:0] c, input logic last);
        if (c == fste_pkg::CH_NUL) begin
            emit_status(1'b1, last);
        end else if (c < fste_pkg::CH_SPACE && c != fste_pkg::CH_TAB &&
                     c != fste_pkg::CH_LF && c != fste_pkg::CH_CR) begin
            emit_status(1'b0, last);
        end else if (c == fste_pkg::CH_PCT) begin
            pred_phase  = fste_pkg::PH_CONV;
            pred_prefix = fste_pkg::PF_NONE;
            if (last)
                emit_status(1'b0, last);
        end else if (last) begin
            emit_status(1'b1, last);
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic last);
        logic [7:0] code;
        bit         closed;
        closed = 0;
        step_out.delete();
        case (pred_phase)
            fste_pkg::PH_SKIP: begin
                if (last)
                    pred_phase = fste_pkg::PH_LIT;
            end
            fste_pkg::PH_T1, fste_pkg::PH_T2, fste_pkg::PH_T3: begin
                if (!last && ((pred_phase == fste_pkg::PH_T1 && c == fste_pkg::CH_S) ||
                              (pred_phase == fste_pkg::PH_T2 && c == fste_pkg::CH_T))) begin
                    pred_phase = 3'(pred_phase + 3'd1);
                end else begin
                    emit_code((pred_phase == fste_pkg::PH_T3 && c == fste_pkg::CH_R) ?
                              fste_pkg::CH_BIG_P : fste_pkg::CH_I);
                    pred_phase = fste_pkg::PH_LIT;
                    literal_byte(c, last);
                end
            end
            fste_pkg::PH_I1, fste_pkg::PH_I2: begin
                if (pred_phase == fste_pkg::PH_I1 && c == fste_pkg::CH_6) begin
                    pred_phase = fste_pkg::PH_I2;
                end else if (pred_phase == fste_pkg::PH_I2 && c == fste_pkg::CH_4) begin
                    pred_prefix = fste_pkg::PF_I64;
                    pred_phase  = fste_pkg::PH_CONV;
                end else begin
                    emit_status(1'b0, last);
                    closed = 1;
                end
                if (!closed && last)
                    emit_status(1'b0, last);
            end
            fste_pkg::PH_CONV: begin
                if (c == "0" || c == "#" || c == "+" || c == "-" || c == fste_pkg::CH_SPACE ||
                    (c >= "1" && c <= "9") || c == ".") begin
                    // flag, width or precision: stay in the conversion
                end else if (c == fste_pkg::CH_STAR) begin
                    emit_code(fste_pkg::CH_STAR);
                end else if (pred_prefix == fste_pkg::PF_NONE && c == fste_pkg::CH_H) begin
                    pred_prefix = fste_pkg::PF_H;
                end else if (pred_prefix == fste_pkg::PF_NONE && c == fste_pkg::CH_SML_L) begin
                    pred_prefix = fste_pkg::PF_L;
                end else if (pred_prefix == fste_pkg::PF_NONE && c == fste_pkg::CH_BIG_L) begin
                    pred_prefix = fste_pkg::PF_BIGL;
                end else if (pred_prefix == fste_pkg::PF_NONE && c == fste_pkg::CH_BIG_I) begin
                    pred_phase = fste_pkg::PH_I1;
                end else begin
                    closed = 1;
                    case (c)
                        "c", "C": code = fste_pkg::CH_I;
                        "d", "i", "o", "u", "x", "X":
                            code = (pred_prefix == fste_pkg::PF_I64) ?
                                   fste_pkg::CH_BIG_I : fste_pkg::CH_I;
                        "e", "E", "f", "g", "G": code = fste_pkg::CH_F;
                        "p": code = fste_pkg::CH_P;
                        "s", "S": begin
                            if (pred_prefix == fste_pkg::PF_H)
                                code = fste_pkg::CH_S;
                            else if (pred_prefix == fste_pkg::PF_L)
                                code = fste_pkg::CH_BIG_S;
                            else
                                code = c;
                        end
                        "t": code = fste_pkg::CH_T;
                        default: code = fste_pkg::CH_NUL;
                    endcase
                    if (code == fste_pkg::CH_NUL) begin
                        emit_status(1'b0, last);
                    end else if (code == fste_pkg::CH_T) begin
                        pred_phase = fste_pkg::PH_T1;
                        if (last) begin
                            emit_code(fste_pkg::CH_I);
                            emit_status(1'b1, last);
                        end
                    end else begin
                        emit_code(code);
                        pred_phase = fste_pkg::PH_LIT;
                        if (last)
                            emit_status(1'b1, last);
                    end
                end
                if (!closed && last)
                    emit_status(1'b0, last);
            end
            default: begin
                pred_phase = fste_pkg::PH_LIT;
                literal_byte(c, last);
            end
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].run_last = 1'b1;
        foreach (step_out[k])
            expected_results.push_back(step_out[k]);
    endtask

    // Sender: offer queued bytes, predict on every accepted transaction
    always @(posedge i_clk) begin
        t_fmt_byte item;
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.char_in    <= fste_pkg::CH_NUL;
            in_ch.buffer_end <= 1'b0;
            tx_gap      = 0;
            pred_phase  = fste_pkg::PH_LIT;
            pred_prefix = fste_pkg::PF_NONE;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_byte(in_ch.char_in, in_ch.buffer_end);
                bytes_taken++;
                tx_gap = tx_quiet ? 0 : $urandom_range(0, 10);
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered byte until it is taken
            end else if (tx_gap > 0) begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                item = pending_bytes.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.char_in    <= item.ch;
                in_ch.buffer_end <= item.last;
                if ($urandom_range(0, 39) == 0)
                    tx_quiet = !tx_quiet;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result against the oldest expectation, drive ready
    always @(posedge i_clk) begin
        fste_pkg::t_result got;
        fste_pkg::t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{code_char: out_ch.code_char, is_status: out_ch.is_status,
                        format_ok: out_ch.format_ok, run_last: out_ch.run_last};
                if (got.is_status)
                    statuses_seen++;
                else
                    codes_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result code=%02h status=%0b ok=%0b last=%0b",
                                              got.code_char, got.is_status, got.format_ok,
                                              got.run_last));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "code=%02h/%02h status=%0b/%0b ok=%0b/%0b last=%0b/%0b (got/want)",
                            got.code_char, want.code_char, got.is_status, want.is_status,
                            got.format_ok, want.format_ok, got.run_last, want.run_last));
                end
                rx_gap = rx_quiet ? 0 : $urandom_range(0, 10);
                if ($urandom_range(0, 29) == 0)
                    rx_quiet = !rx_quiet;
            end
            // Hold off for a long stretch while the sender still has plenty to send
            if (rx_hold_left == 0 && holds_done < 2 && pending_bytes.size() > 40 &&
                codes_seen + statuses_seen >= hold_at) begin
                rx_hold_left = 150;
                holds_done++;
                hold_at = codes_seen + statuses_seen + 100;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus helpers
    task automatic queue_byte(input logic [7:0] c, input logic last);
        pending_bytes.push_back('{ch: c, last: last});
        bytes_queued++;
    endtask

    task automatic queue_text(input string s, input bit end_here);
        for (int k = 0; k < s.len(); k++)
            queue_byte(s[k], end_here && k == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_literal();
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0: c = fste_pkg::CH_TAB;
            1: c = fste_pkg::CH_LF;
            2: c = fste_pkg::CH_CR;
            default: begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == fste_pkg::CH_PCT)
                    c = fste_pkg::CH_SPACE;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pick_flag();
        return conv_flags[$urandom_range(0, conv_flags.len() - 1)];
    endfunction

    // One buffer: literal runs, conversions and some noise, then an ending
    task automatic queue_random_string();
        logic [7:0] text [$];
        logic [7:0] conv;
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 4)) text.push_back(pick_literal());
                9:       text.push_back(8'($urandom_range(0, 255)));
                default: begin
                    text.push_back(fste_pkg::CH_PCT);
                    repeat ($urandom_range(0, 3))
                        text.push_back(($urandom_range(0, 3) == 0) ?
                                       fste_pkg::CH_STAR : pick_flag());
                    case ($urandom_range(0, 9))
                        0: text.push_back(fste_pkg::CH_H);
                        1: text.push_back(fste_pkg::CH_SML_L);
                        2: text.push_back(fste_pkg::CH_BIG_L);
                        3: begin
                            text.push_back(fste_pkg::CH_BIG_I);
                            text.push_back(fste_pkg::CH_6);
                            text.push_back(fste_pkg::CH_4);
                        end
                        4: begin
                            text.push_back(fste_pkg::CH_BIG_I);
                            text.push_back(($urandom_range(0, 1) == 0) ?
                                           fste_pkg::CH_6 : pick_literal());
                        end
                        default: ;
                    endcase
                    if ($urandom_range(0, 11) == 0)
                        conv = 8'($urandom_range(0, 255));
                    else
                        conv = conv_types[$urandom_range(0, conv_types.len() - 1)];
                    text.push_back(conv);
                    if (conv == fste_pkg::CH_T)
                        for (int j = 0; j < $urandom_range(0, 3); j++)
                            text.push_back(tstr_tail[j]);
                end
            endcase
        end
        case ($urandom_range(0, 3))
            0: begin
                // terminator followed by bytes that are skipped
                text.push_back(fste_pkg::CH_NUL);
                repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
                text.push_back(pick_literal());
            end
            1: text.push_back(pick_literal());
            2: begin
                // conversion cut off by the end of the buffer
                text.push_back(fste_pkg::CH_PCT);
                repeat ($urandom_range(0, 2)) text.push_back(pick_flag());
            end
            default: text.push_back(fste_pkg::CH_NUL);
        endcase
        foreach (text[k])
            queue_byte(text[k], k == text.size() - 1);
    endtask

    // Wait until every byte is taken and every result has come, then let it settle
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_check_only(input logic value);
        @(posedge i_clk);
        i_cfg_wr_en     <= 1'b1;
        i_cfg_wr_data   <= value;
        pred_check_only = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Main sequence
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 1'b0;
        pred_check_only = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_check_only(1'b0);

        // Directed strings
        queue_text("%I64d", 0);
        queue_byte(fste_pkg::CH_NUL, 1'b1);
        queue_text("%tstr", 1);
        queue_text("%%", 0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h07, 1'b1);
        queue_byte(8'h1F, 1'b1);
        queue_text("%I3", 1);
        queue_text("%*hS%t", 1);
        queue_text("%5", 1);
        wait_drained();

        // Random strings under alternating settings
        for (int ph = 0; ph < 4; ph++) begin
            set_check_only(ph % 2 == 0);
            while (bytes_queued < 27 + (ph + 1) * 131)
                queue_random_string();
            wait_drained();
        end

        $display("Sent %0d format bytes under %0d check_only settings;",
                 bytes_taken, settings_used);
        $display("checked %0d type codes and %0d status items, %0d long receiver stalls.",
                 codes_seen, statuses_seen, holds_done);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Timeout with %0d results still owed", expected_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fste_pkg.sv
rtl/fste_in_if.sv
rtl/fste_out_if.sv
rtl/fste_decode.sv
rtl/format_spec_type_extractor.sv
rtl/fste_checker.sv
sim/format_spec_type_extractor_tb.sv
